// ----- hw/rtl/timed_event_queue_defines.svh -----
// Assertion macros for the timed event queue RTL, used by teq_ctrl.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef TIMED_EVENT_QUEUE_DEFINES_SVH
`define TIMED_EVENT_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/teq_pkg.sv -----
// Shared types and constants for the timed event queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package teq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 4;
  localparam int DEADLINE_W  = 64;
  localparam int EVENT_ID_W  = 4;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_SCHEDULE   = 2'd0,
    REQ_CANCEL_ID  = 2'd1,
    REQ_POP        = 2'd2,
    REQ_CANCEL_ALL = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t               req_type;
    logic [DEADLINE_W-1:0]   deadline;
    logic [EVENT_ID_W-1:0]   event_id;
    logic [DEADLINE_W-1:0]   current_cycle;
  } in_item_t;

  typedef struct packed {
    logic [DEADLINE_W-1:0]   next_event;
    logic                    popped_valid;
    logic [EVENT_ID_W-1:0]   popped_id;
    logic                    dropped;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic sched;
    logic cancel_one;
    logic pop;
    logic clear;
  } teq_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    req_type_t req_type;
    logic      cancel_hit;
  } teq_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/timed_event_queue.sv -----
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  teq_pkg::in_item_t  (request)
// out_      output     out_valid/out_stall teq_pkg::out_item_t (result)
//
// Schedule, pop and cancel-all: request registered on acceptance, run in ST_EXEC, result valid in ST_DONE.
// Cancel by id: ST_EXEC repeats while an entry matches, one removed per cycle through the shift queue.
// One request in flight; the next is taken the cycle after its result is taken.
// Reset clears entry count and next_event; queue cells need no clearing.
// A stalled result holds its value; the input stays stalled until it leaves.
`default_nettype none

module timed_event_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire teq_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output teq_pkg::out_item_t     out_data
);
  import teq_pkg::*;

  teq_cmd_t cmd;
  teq_sts_t sts;

  teq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  teq_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/teq_ctrl.sv -----
// Request sequencer for the timed event queue.
// Depends on teq_pkg and timed_event_queue_defines.svh.
`default_nettype none
`include "timed_event_queue_defines.svh"

module teq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output teq_pkg::teq_cmd_t      cmd,
  input  wire teq_pkg::teq_sts_t sts
);
  import teq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts.req_type)
          REQ_SCHEDULE: begin
            cmd.sched = 1'b1;
            state_nxt = ST_DONE;
          end
          REQ_CANCEL_ID: begin
            // drop one matching entry per cycle until none is left
            if (sts.cancel_hit) begin
              cmd.cancel_one = 1'b1;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          REQ_POP: begin
            cmd.pop   = 1'b1;
            state_nxt = ST_DONE;
          end
          default: begin
            cmd.clear = 1'b1;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

  `TEQ_ASSERT_IMP(a_busy_while_result, out_valid, in_stall, "input open while result pending")
  `TEQ_ASSERT_NXT(a_accept_starts_exec, in_valid && !in_stall, in_stall && !out_valid, "accepted transaction did not start execution")
  `TEQ_ASSERT_NXT(a_result_frees_input, out_valid && !out_stall, !in_stall && !out_valid, "input not reopened after result taken")
  `TEQ_ASSERT_IMP(a_cancel_needs_hit, cmd.cancel_one, sts.cancel_hit && !cmd.sched && !cmd.pop, "cancel step without a matching entry")

endmodule

`default_nettype wire

// ----- hw/rtl/teq_dpath.sv -----
// Sorted shift-register queue with request and result registers.
// Depends on teq_pkg; driven by teq_ctrl commands.
`default_nettype none

module teq_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire teq_pkg::in_item_t in_data,
  input  wire teq_pkg::teq_cmd_t cmd,
  output teq_pkg::teq_sts_t      sts,
  output teq_pkg::out_item_t     out_data
);
  import teq_pkg::*;

  logic [DEADLINE_W-1:0] deadline_r [QUEUE_DEPTH];
  logic [ID_BITS-1:0]    id_r       [QUEUE_DEPTH];
  logic [CNT_W-1:0]      count_r;
  logic [DEADLINE_W-1:0] next_event_r;

  in_item_t              req_r;
  logic                  popped_valid_r;
  logic [ID_BITS-1:0]    popped_id_r;
  logic                  dropped_r;

  logic [QUEUE_DEPTH-1:0] stop;
  logic [QUEUE_DEPTH-1:0] ins_ge;
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] match_ge;
  logic [ID_BITS-1:0]     req_id;
  logic                   full;
  logic                   do_insert;

  assign req_id    = req_r.event_id[ID_BITS-1:0];
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign do_insert = cmd.sched && !full;

  // Insert point: first cell that is empty or holds a later deadline (wrap-aware).
  always_comb begin
    logic [DEADLINE_W-1:0] diff;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      diff     = req_r.deadline - deadline_r[i];
      stop[i]  = (CNT_W'(i) >= count_r) || diff[DEADLINE_W-1];
      match[i] = (CNT_W'(i) < count_r) && (id_r[i] == req_id);
    end
    ins_ge[0]   = stop[0];
    match_ge[0] = match[0];
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      ins_ge[i]   = ins_ge[i-1] | stop[i];
      match_ge[i] = match_ge[i-1] | match[i];
    end
  end

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic [DEADLINE_W-1:0] below_dl;
      logic [ID_BITS-1:0]    below_id;
      logic [DEADLINE_W-1:0] above_dl;
      logic [ID_BITS-1:0]    above_id;
      logic                  first;

      if (g == 0) begin : g_head
        assign below_dl = req_r.deadline;
        assign below_id = req_id;
        assign first    = ins_ge[0];
      end else begin : g_body
        assign below_dl = deadline_r[g-1];
        assign below_id = id_r[g-1];
        assign first    = ins_ge[g] & ~ins_ge[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign above_dl = deadline_r[g];
        assign above_id = id_r[g];
      end else begin : g_mid
        assign above_dl = deadline_r[g+1];
        assign above_id = id_r[g+1];
      end

      always_ff @(posedge clk) begin
        if (do_insert && ins_ge[g]) begin
          deadline_r[g] <= first ? req_r.deadline : below_dl;
          id_r[g]       <= first ? req_id : below_id;
        end else if (cmd.pop || (cmd.cancel_one && match_ge[g])) begin
          deadline_r[g] <= above_dl;
          id_r[g]       <= above_id;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      next_event_r <= '0;
    end else begin
      if (do_insert) begin
        count_r      <= count_r + CNT_W'(1);
        next_event_r <= ins_ge[0] ? req_r.deadline : deadline_r[0];
      end else if (cmd.cancel_one) begin
        count_r <= count_r - CNT_W'(1);
      end else if (cmd.pop) begin
        if (count_r != '0) begin
          count_r <= count_r - CNT_W'(1);
        end
        next_event_r <= (count_r > CNT_W'(1)) ? deadline_r[1]
                                               : req_r.current_cycle - DEADLINE_W'(1);
      end else if (cmd.clear) begin
        count_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r          <= in_data;
      popped_valid_r <= 1'b0;
      popped_id_r    <= '0;
      dropped_r      <= 1'b0;
    end else if (cmd.sched && full) begin
      dropped_r <= 1'b1;
    end else if (cmd.pop && (count_r != '0)) begin
      popped_valid_r <= 1'b1;
      popped_id_r    <= id_r[0];
    end
  end

  assign sts.req_type   = req_r.req_type;
  assign sts.cancel_hit = match_ge[QUEUE_DEPTH-1];

  assign out_data.next_event   = next_event_r;
  assign out_data.popped_valid = popped_valid_r;
  assign out_data.popped_id    = EVENT_ID_W'(popped_id_r);
  assign out_data.dropped      = dropped_r;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for timed_event_queue: sorted schedule/pop/cancel traffic.
// Depends on teq_pkg and the timed_event_queue RTL; needs no other files.
`timescale 1ns / 1ps

module tb_top;
  import teq_pkg::*;

  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          ITEMS_PHASE  = 362;
  localparam logic [63:0] SIGN_BIT     = 64'h8000_0000_0000_0000;
  localparam logic [EVENT_ID_W-1:0] ID_MASK = EVENT_ID_W'((1 << ID_BITS) - 1);

  // Tracks the sorted queue and holds the results it predicts, oldest first.
  class sched_scoreboard;
    logic [63:0]           slot_dl [QUEUE_DEPTH];
    logic [EVENT_ID_W-1:0] slot_id [QUEUE_DEPTH];
    int                    depth_used;
    logic [63:0]           next_evt;
    out_item_t             pending_results[$];
    int errors, n_sched, n_drop, n_pop, n_pop_hit, n_cancel, n_checked;

    function new();
      depth_used = 0;
      next_evt   = '0;
      foreach (slot_dl[i]) begin
        slot_dl[i] = '0;
        slot_id[i] = '0;
      end
    endfunction

    function void note_request(in_item_t req);
      out_item_t             res;
      int                    pos, keep, i;
      logic [EVENT_ID_W-1:0] rid;
      res = '0;
      rid = req.event_id & ID_MASK;
      case (req.req_type)
        REQ_SCHEDULE: begin
          n_sched++;
          if (depth_used >= QUEUE_DEPTH) begin
            res.dropped = 1'b1;
            n_drop++;
          end else begin
            // insert behind every entry that is not later (wrap-aware), so ties stay in order
            pos = 0;
            while (pos < depth_used && ((req.deadline - slot_dl[pos]) & SIGN_BIT) == 0)
              pos++;
            for (i = depth_used; i > pos; i--) begin
              slot_dl[i] = slot_dl[i-1];
              slot_id[i] = slot_id[i-1];
            end
            slot_dl[pos] = req.deadline;
            slot_id[pos] = rid;
            depth_used++;
            next_evt = slot_dl[0];
          end
        end
        REQ_CANCEL_ID: begin
          n_cancel++;
          keep = 0;
          for (i = 0; i < depth_used; i++) begin
            if (slot_id[i] != rid) begin
              slot_dl[keep] = slot_dl[i];
              slot_id[keep] = slot_id[i];
              keep++;
            end
          end
          depth_used = keep;
        end
        REQ_POP: begin
          n_pop++;
          if (depth_used > 0) begin
            n_pop_hit++;
            res.popped_valid = 1'b1;
            res.popped_id    = slot_id[0];
            for (i = 1; i < depth_used; i++) begin
              slot_dl[i-1] = slot_dl[i];
              slot_id[i-1] = slot_id[i];
            end
            depth_used--;
          end
          next_evt = (depth_used > 0) ? slot_dl[0] : req.current_cycle - 64'd1;
        end
        default: begin
          n_cancel++;
          depth_used = 0;
        end
      endcase
      res.next_event = next_evt;
      pending_results.push_back(res);
    endfunction

    function void compare_field(string fname, logic [63:0] want_v, logic [63:0] got_v);
      if (want_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want_v, got_v);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      compare_field("next_event", want.next_event, got.next_event);
      compare_field("popped_valid", 64'(want.popped_valid), 64'(got.popped_valid));
      compare_field("popped_id", 64'(want.popped_id), 64'(got.popped_id));
      compare_field("dropped", 64'(want.dropped), 64'(got.dropped));
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  sched_scoreboard sb = new();
  int          idle_pct    = 0;
  int          stall_pct   = 0;
  int          cycle_count = 0;
  logic [63:0] clock_now   = '0;

  timed_event_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // values read here are the ones the block saw at this edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, sb.pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_request(input in_item_t req);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic in_item_t mk_req(req_type_t op, logic [63:0] dl,
                                      logic [EVENT_ID_W-1:0] id, logic [63:0] now);
    in_item_t r;
    r.req_type      = op;
    r.deadline      = dl;
    r.event_id      = id;
    r.current_cycle = now;
    return r;
  endfunction

  function automatic logic [63:0] pick_deadline();
    int          sel;
    logic [63:0] d;
    sel = $urandom_range(99);
    if (sel < 40)
      d = clock_now + 64'($urandom_range(200));
    else if (sel < 55 && sb.depth_used > 0)
      d = sb.slot_dl[$urandom_range(sb.depth_used - 1)];   // tie with a queued entry
    else if (sel < 70)
      d = {$urandom, $urandom};
    else if (sel < 85) begin
      case ($urandom_range(3))
        0:       d = '0;
        1:       d = '1;
        2:       d = SIGN_BIT;
        default: d = ~SIGN_BIT;
      endcase
    end else
      // around half the range away, where the wrap-aware order flips
      d = clock_now + SIGN_BIT + 64'($urandom_range(100)) - 64'd50;
    return d;
  endfunction

  // profile 0 fills the queue, 1 drains it, 2 mixes
  function automatic in_item_t random_request(int profile);
    in_item_t r;
    int       roll, w_sched, w_pop, w_cid, sel;
    case (profile)
      0:       begin w_sched = 70; w_pop = 20; w_cid = 8;  end
      1:       begin w_sched = 25; w_pop = 67; w_cid = 6;  end
      default: begin w_sched = 45; w_pop = 38; w_cid = 14; end
    endcase
    roll            = $urandom_range(99);
    r.deadline      = pick_deadline();
    r.event_id      = EVENT_ID_W'($urandom_range(15));
    sel             = $urandom_range(99);
    r.current_cycle = (sel < 80) ? clock_now :
                      (sel < 92) ? {$urandom, $urandom} :
                      (sel < 96) ? 64'd0 : '1;
    if (roll < w_sched)
      r.req_type = REQ_SCHEDULE;
    else if (roll < w_sched + w_pop)
      r.req_type = REQ_POP;
    else if (roll < w_sched + w_pop + w_cid) begin
      r.req_type = REQ_CANCEL_ID;
      if (sb.depth_used > 0 && $urandom_range(99) < 70)
        r.event_id = sb.slot_id[$urandom_range(sb.depth_used - 1)];
    end else
      r.req_type = REQ_CANCEL_ALL;
    return r;
  endfunction

  initial begin
    int k, ph, profile;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-queue corners, ordering corners, full queue, cancels
    send_request(mk_req(REQ_POP, 64'd0, 4'd0, 64'd0));
    send_request(mk_req(REQ_CANCEL_ID, 64'd0, 4'd5, 64'd10));
    send_request(mk_req(REQ_CANCEL_ALL, '1, 4'd15, '1));
    send_request(mk_req(REQ_SCHEDULE, 64'd100, 4'd1, 64'd0));
    send_request(mk_req(REQ_SCHEDULE, 64'd100, 4'd2, 64'd0));
    send_request(mk_req(REQ_SCHEDULE, 64'd50, 4'd3, 64'd0));
    send_request(mk_req(REQ_SCHEDULE, '1, 4'd15, 64'd0));
    send_request(mk_req(REQ_SCHEDULE, 64'd0, 4'd0, 64'd0));
    send_request(mk_req(REQ_SCHEDULE, SIGN_BIT, 4'd7, 64'd0));
    send_request(mk_req(REQ_SCHEDULE, ~SIGN_BIT, 4'd8, 64'd0));
    for (k = 0; k < 9; k++)
      send_request(mk_req(REQ_SCHEDULE, 64'(60 + 20 * (k % 4)),
                          (k % 2) ? 4'd4 : 4'd9, 64'd0));
    send_request(mk_req(REQ_SCHEDULE, 64'd1, 4'd6, 64'd0));   // queue full: dropped
    send_request(mk_req(REQ_CANCEL_ID, '1, 4'd4, '1));
    send_request(mk_req(REQ_POP, '1, 4'd0, 64'd5));
    send_request(mk_req(REQ_POP, 64'd0, 4'd15, '1));
    send_request(mk_req(REQ_CANCEL_ALL, 64'd0, 4'd0, 64'd0));
    send_request(mk_req(REQ_POP, 64'd0, 4'd0, 64'h1234_5678_9abc_def0));

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 84; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      clock_now = {$urandom, $urandom};
      profile   = 0;
      for (k = 0; k < ITEMS_PHASE; k++) begin
        if (k % 30 == 0) profile = $urandom_range(2);
        clock_now += 64'($urandom_range(1, 40));
        send_request(random_request(profile));
      end
    end
    in_valid <= 1'b0;
    // wait on the clock so the last accepted transaction is in the scoreboard
    @(posedge clk);

    while (sb.pending_results.size() > 0) @(posedge clk);
    repeat (25) @(posedge clk);

    $display("Run covered %0d schedules (%0d dropped as full), %0d pops (%0d took an entry),",
             sb.n_sched, sb.n_drop, sb.n_pop, sb.n_pop_hit);
    $display("%0d cancels and %0d checked results under four idle/stall mixes.",
             sb.n_cancel, sb.n_checked);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/teq_pkg.sv
hw/rtl/teq_ctrl.sv
hw/rtl/teq_dpath.sv
hw/rtl/timed_event_queue.sv
tb/tb_top.sv
